// ----- sv/keypad_speed_pwm_generator_defines.svh -----
// ---------------------------------------------------------------------------
// keypad_speed_pwm_generator_defines
// assertion macros used by the keypad pwm generator rtl
// ---------------------------------------------------------------------------
`ifndef KEYPAD_SPEED_PWM_GENERATOR_DEFINES_SVH
`define KEYPAD_SPEED_PWM_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// plain property checked on every clock edge out of reset
`define KSP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ksp assertion failed");

// implication with the consequent checked in the cycle after the antecedent
`define KSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ksp assertion failed");

`else

`define KSP_ASSERT(lbl, clk, rst_n, prop)
`define KSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/ksp_pkg.sv -----
// ---------------------------------------------------------------------------
// ksp_pkg
// types and constants of the keypad controlled pwm generator
// ---------------------------------------------------------------------------
package ksp_pkg;

	localparam int PERIOD_W = 16;
	localparam int DUTY_W   = 13;
	localparam int SPEED_W  = 4;
	localparam int KEYS     = 16;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4000;
	localparam logic [DUTY_W-1:0]   DUTY_RESET   = 13'd400;
	localparam logic [SPEED_W-1:0]  SPEED_LEVELS = 4'd9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP    = 8'd1;

	// item kinds
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_KEY  = 1'b1;

	// key codes, digits are their own value
	localparam logic [4:0] KEY_OTHER = 5'h10;
	localparam logic [4:0] KEY_STOP  = 5'h00;

	// bit column*4+row to key code
	localparam logic [4:0] KEY_CODE [KEYS] = '{
		5'd1, 5'd4, 5'd7, KEY_OTHER,
		5'd2, 5'd5, 5'd8, KEY_STOP,
		5'd3, 5'd6, 5'd9, KEY_OTHER,
		KEY_OTHER, KEY_OTHER, KEY_OTHER, KEY_OTHER
	};

	typedef struct packed {
		logic                action;
		logic [KEYS-1:0]     key_matrix;
	} item_t;

	typedef struct packed {
		logic                pwm_level;
		logic [SPEED_W-1:0]  speed_shown;
		logic                is_running;
	} result_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_ticks;
		logic [DUTY_W-1:0]   duty_step;
	} cfg_t;

	typedef struct packed {
		logic                digit;
		logic                stop;
		logic [SPEED_W-1:0]  value;
	} key_t;

endpackage

// ----- sv/ksp_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// ksp_cfg_regs
// period and duty step registers behind the configuration write port
// ---------------------------------------------------------------------------
module ksp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ksp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ksp_pkg::CFG_DATA_W-1:0] cfg_data,
	output ksp_pkg::cfg_t                 cfg
);
	import ksp_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [DUTY_W-1:0]   duty_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			duty_q   <= DUTY_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_PERIOD_TICKS) begin
				period_q <= cfg_data[PERIOD_W-1:0];
			end
			if (cfg_index == REG_DUTY_STEP) begin
				duty_q <= cfg_data[DUTY_W-1:0];
			end
		end
	end

	assign cfg.period_ticks = period_q;
	assign cfg.duty_step    = duty_q;

endmodule

// ----- sv/ksp_key_decode.sv -----
// ---------------------------------------------------------------------------
// ksp_key_decode
// priority decode of the active-low 4x4 key matrix
// ---------------------------------------------------------------------------
module ksp_key_decode (
	input  logic [ksp_pkg::KEYS-1:0] key_matrix,
	output ksp_pkg::key_t            key
);
	import ksp_pkg::*;

	logic [4:0] code;

	// lowest pressed bit wins, so scan from the top down
	always_comb begin
		code = KEY_OTHER;
		for (int i = KEYS - 1; i >= 0; i--) begin
			if (!key_matrix[i]) begin
				code = KEY_CODE[i];
			end
		end
	end

	always_comb begin
		key.stop  = (key_matrix != '1) && (code == KEY_STOP);
		key.digit = (key_matrix != '1) && (code != KEY_STOP) && (code != KEY_OTHER);
		key.value = code[SPEED_W-1:0];
	end

endmodule

// ----- sv/ksp_pwm_core.sv -----
// ---------------------------------------------------------------------------
// ksp_pwm_core
// generator state and its combinational next-state update for one word
// ---------------------------------------------------------------------------
module ksp_pwm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  ksp_pkg::item_t     item,
	input  ksp_pkg::cfg_t      cfg,
	output ksp_pkg::result_t   next_result
);
	import ksp_pkg::*;

	`include "keypad_speed_pwm_generator_defines.svh"

	key_t                 key;
	logic                 running_q, running_d;
	logic                 level_q, level_d;
	logic [SPEED_W-1:0]   speed_q, speed_d;
	logic [PERIOD_W-1:0]  count_q, count_d;
	logic [PERIOD_W+1:0]  high_prod;
	logic [PERIOD_W-1:0]  high_len;
	logic [PERIOD_W-1:0]  low_len;

	ksp_key_decode u_key_decode (
		.key_matrix (item.key_matrix),
		.key        (key)
	);

	// high phase length, clamped to the period
	assign high_prod = (PERIOD_W+2)'(speed_q) * (PERIOD_W+2)'(cfg.duty_step);
	assign high_len  = (high_prod > (PERIOD_W+2)'(cfg.period_ticks))
		? cfg.period_ticks : high_prod[PERIOD_W-1:0];
	assign low_len   = cfg.period_ticks - high_len;

	always_comb begin
		running_d = running_q;
		level_d   = level_q;
		speed_d   = speed_q;
		count_d   = count_q;
		if (item.action == ACT_KEY) begin
			// keys a-d, star, pound and no key leave everything as it is
			if (key.digit) begin
				if (!running_q) begin
					running_d = 1'b1;
					level_d   = 1'b0;
					count_d   = cfg.period_ticks;
				end
				speed_d = (key.value > SPEED_LEVELS) ? SPEED_LEVELS : key.value;
			end else if (key.stop) begin
				running_d = 1'b0;
				level_d   = 1'b0;
				speed_d   = '0;
				count_d   = '0;
			end
		end else if (running_q) begin
			if (count_q > PERIOD_W'(1)) begin
				count_d = count_q - PERIOD_W'(1);
			end else if (!level_q) begin
				level_d = 1'b1;
				count_d = (high_len == '0) ? PERIOD_W'(1) : high_len;
			end else begin
				level_d = 1'b0;
				count_d = (low_len == '0) ? PERIOD_W'(1) : low_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			level_q   <= 1'b0;
			speed_q   <= '0;
			count_q   <= '0;
		end else if (step) begin
			running_q <= running_d;
			level_q   <= level_d;
			speed_q   <= speed_d;
			count_q   <= count_d;
		end
	end

	assign next_result.pwm_level   = level_d;
	assign next_result.speed_shown = speed_d;
	assign next_result.is_running  = running_d;

	`KSP_ASSERT(a_speed_iff_running, clk, arst_n, (speed_q != '0) == running_q)
	`KSP_ASSERT(a_level_needs_run, clk, arst_n, !level_q || running_q)
	`KSP_ASSERT(a_speed_in_range, clk, arst_n, speed_q <= SPEED_LEVELS)
	`KSP_ASSERT_NEXT(a_tick_decrements, clk, arst_n,
		step && (item.action == ACT_TICK) && running_q && (count_q > PERIOD_W'(1)),
		(count_q == $past(count_q) - PERIOD_W'(1)) && (level_q == $past(level_q)))

endmodule

// ----- sv/keypad_speed_pwm_generator.sv -----
// ---------------------------------------------------------------------------
// keypad_speed_pwm_generator
// keypad controlled pwm generator: timer ticks and key events in, level out
// ---------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  item     | item_valid / item_stall      | item (action, key_matrix)
//  result   | result_valid / result_stall  | result (level, speed, run flag)
//  cfg      | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// one word per cycle while nothing stalls; a word passes the input register,
// then the result register, to the output, and the state updates with it
// reset clears the state, the valid flags and loads the register defaults
// a stalled result holds; the input register keeps taking words until it
// is full behind a stalled result, then item_stall rises
// cfg is always ready and takes effect on the next edge
// ---------------------------------------------------------------------------
module keypad_speed_pwm_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  ksp_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output ksp_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ksp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ksp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ksp_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t next_result;
	result_t result_q;
	logic    result_valid_q;

	ksp_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the held word moves on when the result register is free or draining
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	ksp_pwm_core u_pwm_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.cfg         (cfg),
		.next_result (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- test/tb_keypad_speed_pwm_generator.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_keypad_speed_pwm_generator
// drives timer ticks and keypad words into the pwm generator, predicts the
// level, speed and run flag of every word and checks each result word in
// order, under random gaps on both channels and several register settings
// ---------------------------------------------------------------------------
module tb_keypad_speed_pwm_generator;
	import ksp_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int BATCH_WORDS  = 100;
	localparam int SETTINGS_RUN = 12;
	localparam int STOP_BIT     = 7;
	localparam logic [4:0] KEY_NONE = 5'h1F;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	item_t                 item = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predicted generator state and registers
	logic [PERIOD_W-1:0] period_ticks = PERIOD_RESET;
	logic [DUTY_W-1:0]   duty_step = DUTY_RESET;
	logic                pwm_on = 1'b0;
	logic                pwm_high = 1'b0;
	logic [SPEED_W-1:0]  pwm_speed = '0;
	logic [PERIOD_W-1:0] ticks_left = '0;

	result_t expected_levels[$];
	int errors = 0;
	int words_sent = 0;
	int results_checked = 0;
	int cfg_writes = 0;
	int pwm_edges = 0;
	int cycles = 0;
	int send_gap_pct = 20;
	int recv_stall_pct = 55;

	keypad_speed_pwm_generator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t timeout with %0d result words outstanding", $time,
				expected_levels.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// first pressed key in column-major order
	function automatic logic [4:0] decode_key(logic [KEYS-1:0] m);
		int col;
		int row;
		for (int b = 0; b < KEYS; b++) begin
			if (!m[b]) begin
				col = b / 4;
				row = b % 4;
				if (col == 3)
					return KEY_OTHER;
				if (row == 3)
					return (col == 1) ? KEY_STOP : KEY_OTHER;
				return 5'(row * 3 + col + 1);
			end
		end
		return KEY_NONE;
	endfunction

	function automatic result_t step_pwm(item_t w);
		logic [4:0] k;
		int high_len;
		int low_len;
		result_t r;
		if (w.action == ACT_KEY) begin
			k = decode_key(w.key_matrix);
			if (k >= 5'd1 && k <= 5'd9) begin
				if (!pwm_on) begin
					pwm_on = 1'b1;
					pwm_high = 1'b0;
					ticks_left = period_ticks;
				end
				pwm_speed = (k > 5'(SPEED_LEVELS)) ? SPEED_LEVELS : k[SPEED_W-1:0];
			end else if (k == KEY_STOP) begin
				pwm_on = 1'b0;
				pwm_high = 1'b0;
				pwm_speed = '0;
				ticks_left = '0;
			end
		end else if (pwm_on) begin
			if (ticks_left > 1) begin
				ticks_left = ticks_left - 1'b1;
			end else begin
				high_len = int'(pwm_speed) * int'(duty_step);
				if (high_len > int'(period_ticks))
					high_len = int'(period_ticks);
				low_len = int'(period_ticks) - high_len;
				pwm_edges++;
				if (!pwm_high) begin
					pwm_high = 1'b1;
					ticks_left = (high_len == 0) ? PERIOD_W'(1) : PERIOD_W'(high_len);
				end else begin
					pwm_high = 1'b0;
					ticks_left = (low_len == 0) ? PERIOD_W'(1) : PERIOD_W'(low_len);
				end
			end
		end
		r.pwm_level = pwm_high;
		r.speed_shown = pwm_speed;
		r.is_running = pwm_on;
		return r;
	endfunction

	function automatic void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name,
				exp_val, act_val);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_levels.size() == 0) begin
					$display("%0t result word with none expected: actual %p", $time, result);
					errors++;
				end else begin
					want = expected_levels.pop_front();
					check_field("pwm_level", want.pwm_level, result.pwm_level);
					check_field("speed_shown", want.speed_shown, result.speed_shown);
					check_field("is_running", want.is_running, result.is_running);
					results_checked++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				if (cfg_index == REG_PERIOD_TICKS)
					period_ticks = cfg_data;
				else if (cfg_index == REG_DUTY_STEP)
					duty_step = cfg_data[DUTY_W-1:0];
			end
			if (item_valid && !item_stall)
				expected_levels.push_back(step_pwm(item));
		end
	end

	task automatic send_word(input item_t w);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [PERIOD_W-1:0] p, input logic [DUTY_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= REG_PERIOD_TICKS;
		cfg_data <= p;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_DUTY_STEP;
		cfg_data <= CFG_DATA_W'(d);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic item_t key_word(logic [KEYS-1:0] m);
		item_t w;
		w.action = ACT_KEY;
		w.key_matrix = m;
		return w;
	endfunction

	function automatic item_t tick_word();
		item_t w;
		w.action = ACT_TICK;
		w.key_matrix = KEYS'($urandom);
		return w;
	endfunction

	// key at bit b wins, higher bits are random noise
	function automatic item_t press_bit(int b);
		logic [KEYS-1:0] m;
		m = KEYS'($urandom);
		m = m | ((KEYS'(1) << b) - KEYS'(1));
		m[b] = 1'b0;
		return key_word(m);
	endfunction

	function automatic int digit_bit(int d);
		return ((d - 1) % 3) * 4 + (d - 1) / 3;
	endfunction

	task automatic test_key_decode();
		send_word(tick_word());
		send_word(press_bit(STOP_BIT));
		send_word(key_word('1));
		// walking zero: each key alone, stop and restart on the way
		for (int b = 0; b < KEYS; b++)
			send_word(key_word(~(KEYS'(1) << b)));
		send_word(key_word('0));
	endtask

	task automatic test_phase_edges();
		wait_idle();
		// high time clamps to the period, so the low phase is one tick
		write_cfg(3, 2);
		send_word(press_bit(STOP_BIT));
		send_word(press_bit(digit_bit(9)));
		repeat (8) send_word(tick_word());
	endtask

	task automatic run_batch();
		int r;
		int pick;
		send_word(press_bit(digit_bit($urandom_range(1, 9))));
		repeat (BATCH_WORDS - 1) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				send_word(tick_word());
			end else if (r < 90) begin
				send_word(press_bit(digit_bit($urandom_range(1, 9))));
			end else if (r < 94) begin
				send_word(press_bit(STOP_BIT));
			end else if (r < 98) begin
				send_word(key_word(KEYS'($urandom)));
			end else begin
				pick = $urandom_range(0, 5);
				send_word(press_bit(pick == 0 ? 3 : (pick == 1 ? 11 : 10 + pick)));
			end
		end
	endtask

	task automatic test_random_settings();
		logic [PERIOD_W-1:0] p;
		logic [DUTY_W-1:0] d;
		int r;
		for (int s = 0; s < SETTINGS_RUN; s++) begin
			if (s == SETTINGS_RUN / 3) begin
				send_gap_pct = 55;
				recv_stall_pct = 20;
			end else if (s == 2 * SETTINGS_RUN / 3) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			case (s)
				0: begin p = 1; d = 0; end
				1: begin p = 16'hFFFF; d = 7281; end
				6: begin p = 1; d = 7281; end
				9: begin p = 16'hFFFF; d = 0; end
				default: begin
					p = ($urandom_range(0, 3) == 0) ? PERIOD_W'($urandom_range(41, 65535))
						: PERIOD_W'($urandom_range(1, 40));
					r = $urandom_range(0, 9);
					d = (r < 6) ? DUTY_W'($urandom_range(0, 8))
						: ((r < 9) ? DUTY_W'($urandom_range(0, 7281)) : DUTY_W'(0));
				end
			endcase
			wait_idle();
			write_cfg(p, d);
			run_batch();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_key_decode();
		test_phase_edges();
		test_random_settings();
		wait_idle();
		if (expected_levels.size() != 0) begin
			$display("%0t %0d result words never arrived", $time, expected_levels.size());
			errors++;
		end
		$display("sent %0d words (ticks and keypad), checked %0d result words", words_sent,
			results_checked);
		$display("%0d register writes, %0d pwm edges predicted, %0d errors", cfg_writes,
			pwm_edges, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
